>>> rtl/core/eiksw_pkg.sv
// ----------------------------------------------------------------------------
// eiksw_pkg
// Shared widths, stage types and the step function of the eikonal cell solver.
// ----------------------------------------------------------------------------
package eiksw_pkg;

  localparam int VAL_W     = 32;               // signed distance word
  localparam int SLOTS     = 6;                // neighbour slots
  localparam int CNT_W     = 3;                // neighbour count / rank width
  localparam int H_W       = 21;               // grid spacing register
  localparam int HH_W      = 2 * H_W;          // h squared
  localparam int SQ_W      = 2 * VAL_W;        // square of a magnitude difference
  localparam int ARG_W     = 44;               // root argument, holds 3*h^2
  localparam int ROOT_W    = ARG_W / 2;        // root width
  localparam int REM_W     = ROOT_W + 2;       // partial remainder of the root
  localparam int SQ_STEPS  = 2;                // root bits resolved per stage
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
  localparam int NUM_W     = 33;               // numerator of the divide by three
  localparam int RCP_W     = 32;               // reciprocal of three
  localparam int RCP_SHIFT = 33;               // scaling of the reciprocal
  localparam int NL_W      = 17;               // low part of the split numerator
  localparam int NH_W      = NUM_W - NL_W;     // high part of the split numerator
  localparam int PROD_W    = NUM_W + RCP_W;    // full reciprocal product

  // 2^33 / 3 rounded up: exact floor division for numerators below 2^33
  localparam logic [RCP_W-1:0] RCP_THIRD = 32'hAAAA_AAAB;

  localparam logic [H_W-1:0] H_RESET = H_W'(65536);

  // front end fields carried alongside the root and divide pipelines
  typedef struct packed {
    logic             iface;
    logic [VAL_W-1:0] home;
    logic [VAL_W-1:0] magh;
    logic             neg;
    logic [VAL_W:0]   d1;
    logic             c1;
    logic [VAL_W:0]   s01;
    logic [VAL_W+1:0] s012;
    logic [VAL_W-1:0] p2;
  } side_t;

  typedef struct packed {
    logic             iface;
    logic [VAL_W-1:0] home;
    logic [VAL_W-1:0] magh;
    logic             neg;
    logic [VAL_W:0]   d2;
    logic [VAL_W-1:0] p2;
    logic             c2;
  } late_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [ARG_W-1:0]  x;
  } sqrt_t;

  // one bit of the floor square root
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [REM_W+1:0] rt;
    logic [REM_W+1:0] tr;
    sqrt_t            o;
    rt = {s.rem, s.x[ARG_W-1 -: 2]};
    tr = {2'b00, s.root, 2'b01};
    if (rt >= tr) begin
      o.rem  = REM_W'(rt - tr);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(rt);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.x = {s.x[ARG_W-3:0], 2'b00};
    return o;
  endfunction

endpackage

>>> rtl/core/eikonal_sweep_cell_update_core.sv
// ----------------------------------------------------------------------------
// eikonal_sweep_cell_update_core
// Fully pipelined local eikonal solve of one level-set cell.
// ----------------------------------------------------------------------------
// The core takes one cell per clock: busy never rises, so a start is a
// transfer in every cycle it is high. Each result is shown on out_* with
// out_valid high for exactly one cycle, in start order; the receiver
// cannot hold it off. The pipe runs through eight stages of sort and
// squaring, the bit-per-step square root (11 stages of two bits) and
// the two-stage reciprocal multiply that divides by three. The spacing
// register is taken on any cycle cfg_valid is high (cfg_ready stays high)
// and must only change while no cell is in flight.
// ----------------------------------------------------------------------------
module eikonal_sweep_cell_update_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_is_interface,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_home_value,
  input  logic [eiksw_pkg::CNT_W-1:0]      in_neighbour_count,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_a,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_b,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_c,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_d,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_e,
  input  logic [eiksw_pkg::VAL_W-1:0]      in_neighbour_f,
  output logic                             out_valid,
  output logic [eiksw_pkg::VAL_W-1:0]      out_new_value,
  output logic                             out_was_updated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eiksw_pkg::H_W-1:0]        cfg_data
);
  import eiksw_pkg::*;

  logic                 accept;
  logic [H_W-1:0]       h_r;

  // input stage
  logic [VAL_W-1:0]     nb_in [SLOTS];
  logic [VAL_W-1:0]     mag_in [SLOTS];
  logic [CNT_W-1:0]     cnt_in;
  logic                 v1_r;
  logic                 iface1_r;
  logic [VAL_W-1:0]     home1_r;
  logic [VAL_W-1:0]     magh1_r;
  logic [CNT_W-1:0]     cnt1_r;
  logic [VAL_W-1:0]     mag1_r [SLOTS];
  logic [SLOTS-1:0]     sgn1_r;

  // rank stage
  logic [CNT_W-1:0]     rank_nxt [SLOTS];
  logic                 v2_r;
  logic                 iface2_r;
  logic [VAL_W-1:0]     home2_r;
  logic [VAL_W-1:0]     magh2_r;
  logic [CNT_W-1:0]     cnt2_r;
  logic [CNT_W-1:0]     rank2_r [SLOTS];
  logic [VAL_W-1:0]     mag2_r [SLOTS];
  logic [SLOTS-1:0]     sgn2_r;

  // select stage
  logic [VAL_W-1:0]     p0_nxt, p1_nxt, p2_nxt;
  logic                 neg_nxt;
  logic                 v3_r;
  logic                 iface3_r;
  logic [VAL_W-1:0]     home3_r;
  logic [VAL_W-1:0]     magh3_r;
  logic [CNT_W-1:0]     cnt3_r;
  logic [VAL_W-1:0]     p0_3_r, p1_3_r, p2_3_r;
  logic                 neg3_r;

  // difference / square / argument stages
  side_t                side4_nxt;
  logic                 v4_r, v5_r, v6_r, v7_r, v8_r;
  side_t                side4_r, side5_r, side6_r, side7_r, side8_r;
  logic [HH_W-1:0]      hh4_r, hh5_r;
  logic [VAL_W-1:0]     df01_4_r, df12_4_r, df02_4_r;
  logic [SQ_W-1:0]      sq01_5_r, sq12_5_r, sq02_5_r;
  logic [HH_W:0]        hh2_nxt;
  logic [SQ_W-1:0]      arg2_diff;
  logic [ARG_W-1:0]     arg2_6_r, arg2_7_r, arg2_8_r;
  logic [SQ_W-1:0]      t6_r, sq02_6_r, sum3_7_r;
  logic [ARG_W-1:0]     hh3_6_r, hh3_7_r;
  logic [ARG_W-1:0]     arg3_8_r;
  logic [SQ_W-1:0]      arg3_diff;

  // root pipeline
  sqrt_t                sq2_in [SQ_STAGES];
  sqrt_t                sq3_in [SQ_STAGES];
  side_t                sdq_in [SQ_STAGES];
  logic                 vq_in  [SQ_STAGES];
  sqrt_t                sq2_r  [SQ_STAGES];
  sqrt_t                sq3_r  [SQ_STAGES];
  side_t                sdq_r  [SQ_STAGES];
  logic                 vq_r   [SQ_STAGES];
  side_t                sdq_last;

  // two-neighbour estimate
  logic [VAL_W+1:0]     s2sum;
  late_t                late_f1_nxt;
  logic                 vf1_r;
  late_t                late_f1_r;
  logic [NUM_W-1:0]     n3_f1_r;

  // divide-by-three pipeline
  late_t                ldv_in;
  logic [NL_W+RCP_W-1:0] pl_r;
  logic [NH_W+RCP_W-1:0] ph_r;
  late_t                ldv1_r, ldv2_r;
  logic                 vdv1_r, vdv2_r;
  logic [PROD_W-1:0]    prod;
  logic [VAL_W:0]       q_r;
  late_t                ldv_last;

  // decision and output
  logic [VAL_W:0]       d_nxt;
  logic                 vfa_r;
  logic [VAL_W:0]       d_fa_r;
  logic                 upd_fa_r;
  logic                 neg_fa_r;
  logic                 iface_fa_r;
  logic [VAL_W-1:0]     home_fa_r;
  logic [VAL_W-1:0]     neg_d;
  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_new_value_r;
  logic                 out_was_updated_r;

  // The pipeline never stalls, so the core is always ready.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      h_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: take magnitudes of all slots and clamp the count at six.
  // --------------------------------------------------------------------------
  assign nb_in[0] = in_neighbour_a;
  assign nb_in[1] = in_neighbour_b;
  assign nb_in[2] = in_neighbour_c;
  assign nb_in[3] = in_neighbour_d;
  assign nb_in[4] = in_neighbour_e;
  assign nb_in[5] = in_neighbour_f;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      mag_in[i] = nb_in[i][VAL_W-1] ? (~nb_in[i] + VAL_W'(1)) : nb_in[i];
    end
    cnt_in = (in_neighbour_count > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : in_neighbour_count;
  end

  always_ff @(posedge clk) begin
    iface1_r <= in_is_interface;
    home1_r  <= in_home_value;
    magh1_r  <= in_home_value[VAL_W-1] ? (~in_home_value + VAL_W'(1)) : in_home_value;
    cnt1_r   <= cnt_in;
    for (int i = 0; i < SLOTS; i++) begin
      mag1_r[i] <= mag_in[i];
      sgn1_r[i] <= nb_in[i][VAL_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: stable rank of each valid slot; earlier slots win ties.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rank_nxt[i] = '0;
      for (int j = 0; j < SLOTS; j++) begin
        if (j != i && CNT_W'(j) < cnt1_r &&
            (mag1_r[j] < mag1_r[i] || (mag1_r[j] == mag1_r[i] && j < i))) begin
          rank_nxt[i] = rank_nxt[i] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    iface2_r <= iface1_r;
    home2_r  <= home1_r;
    magh2_r  <= magh1_r;
    cnt2_r   <= cnt1_r;
    sgn2_r   <= sgn1_r;
    for (int i = 0; i < SLOTS; i++) begin
      rank2_r[i] <= rank_nxt[i];
      mag2_r[i]  <= mag1_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the three smallest; empty positions read as zero.
  // --------------------------------------------------------------------------
  always_comb begin
    p0_nxt  = '0;
    p1_nxt  = '0;
    p2_nxt  = '0;
    neg_nxt = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CNT_W'(i) < cnt2_r) begin
        if (rank2_r[i] == CNT_W'(0)) p0_nxt = p0_nxt | mag2_r[i];
        if (rank2_r[i] == CNT_W'(1)) p1_nxt = p1_nxt | mag2_r[i];
        if (rank2_r[i] == CNT_W'(2)) p2_nxt = p2_nxt | mag2_r[i];
        if (rank2_r[i] < CNT_W'(3))  neg_nxt = neg_nxt | sgn2_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    iface3_r <= iface2_r;
    home3_r  <= home2_r;
    magh3_r  <= magh2_r;
    cnt3_r   <= cnt2_r;
    p0_3_r   <= p0_nxt;
    p1_3_r   <= p1_nxt;
    p2_3_r   <= p2_nxt;
    neg3_r   <= neg_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 4: one-neighbour estimate, sums and absolute differences.
  // --------------------------------------------------------------------------
  always_comb begin
    side4_nxt.iface = iface3_r;
    side4_nxt.home  = home3_r;
    side4_nxt.magh  = magh3_r;
    side4_nxt.neg   = neg3_r;
    side4_nxt.d1    = {1'b0, p0_3_r} + (VAL_W+1)'(h_r);
    side4_nxt.c1    = side4_nxt.d1 > {1'b0, p1_3_r};
    side4_nxt.s01   = {1'b0, p0_3_r} + {1'b0, p1_3_r};
    side4_nxt.s012  = {2'b00, p0_3_r} + {2'b00, p1_3_r} + {2'b00, p2_3_r};
    side4_nxt.p2    = p2_3_r;
  end

  always_ff @(posedge clk) begin
    side4_r  <= side4_nxt;
    hh4_r    <= HH_W'(h_r) * HH_W'(h_r);
    df01_4_r <= (p1_3_r > p0_3_r) ? p1_3_r - p0_3_r : p0_3_r - p1_3_r;
    df12_4_r <= (p1_3_r > p2_3_r) ? p1_3_r - p2_3_r : p2_3_r - p1_3_r;
    df02_4_r <= (p0_3_r > p2_3_r) ? p0_3_r - p2_3_r : p2_3_r - p0_3_r;
  end

  // Stage 5: squares.
  always_ff @(posedge clk) begin
    side5_r  <= side4_r;
    hh5_r    <= hh4_r;
    sq01_5_r <= SQ_W'(df01_4_r) * SQ_W'(df01_4_r);
    sq12_5_r <= SQ_W'(df12_4_r) * SQ_W'(df12_4_r);
    sq02_5_r <= SQ_W'(df02_4_r) * SQ_W'(df02_4_r);
  end

  // Stage 6: two-neighbour root argument, clamped at zero.
  assign hh2_nxt   = {hh5_r, 1'b0};
  assign arg2_diff = SQ_W'(hh2_nxt) - sq01_5_r;

  always_ff @(posedge clk) begin
    side6_r  <= side5_r;
    arg2_6_r <= (sq01_5_r >= SQ_W'(hh2_nxt)) ? '0 : arg2_diff[ARG_W-1:0];
    t6_r     <= sq01_5_r + sq12_5_r;
    sq02_6_r <= sq02_5_r;
    hh3_6_r  <= ARG_W'(hh2_nxt) + ARG_W'(hh5_r);
  end

  // Stage 7: finish the sum of squared differences.
  always_ff @(posedge clk) begin
    side7_r  <= side6_r;
    arg2_7_r <= arg2_6_r;
    sum3_7_r <= t6_r + sq02_6_r;
    hh3_7_r  <= hh3_6_r;
  end

  // Stage 8: three-neighbour root argument, clamped at zero.
  assign arg3_diff = SQ_W'(hh3_7_r) - sum3_7_r;

  always_ff @(posedge clk) begin
    side8_r  <= side7_r;
    arg2_8_r <= arg2_7_r;
    arg3_8_r <= (sum3_7_r >= SQ_W'(hh3_7_r)) ? '0 : arg3_diff[ARG_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Both floor roots in parallel, two result bits per stage.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        sq2_in[k] = '{rem: '0, root: '0, x: arg2_8_r};
        sq3_in[k] = '{rem: '0, root: '0, x: arg3_8_r};
        sdq_in[k] = side8_r;
        vq_in[k]  = v8_r;
      end else begin
        sq2_in[k] = sq2_r[k-1];
        sq3_in[k] = sq3_r[k-1];
        sdq_in[k] = sdq_r[k-1];
        vq_in[k]  = vq_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      sq2_r[k] <= sqrt_step(sqrt_step(sq2_in[k]));
      sq3_r[k] <= sqrt_step(sqrt_step(sq3_in[k]));
      sdq_r[k] <= sdq_in[k];
    end
  end

  // --------------------------------------------------------------------------
  // Two-neighbour estimate and the three-neighbour numerator.
  // --------------------------------------------------------------------------
  assign sdq_last = sdq_r[SQ_STAGES-1];
  assign s2sum    = {1'b0, sdq_last.s01} + (VAL_W+2)'(sq2_r[SQ_STAGES-1].root);

  always_comb begin
    late_f1_nxt.iface = sdq_last.iface;
    late_f1_nxt.home  = sdq_last.home;
    late_f1_nxt.magh  = sdq_last.magh;
    late_f1_nxt.neg   = sdq_last.neg;
    late_f1_nxt.d2    = sdq_last.c1 ? s2sum[VAL_W+1:1] : sdq_last.d1;
    late_f1_nxt.p2    = sdq_last.p2;
    late_f1_nxt.c2    = 1'b0;
  end

  // The numerator stays below 2^33: three magnitudes of at most 2^31 and a
  // root below 2^22.
  always_ff @(posedge clk) begin
    late_f1_r <= late_f1_nxt;
    n3_f1_r   <= NUM_W'(sdq_last.s012) + NUM_W'(sq3_r[SQ_STAGES-1].root);
  end

  // --------------------------------------------------------------------------
  // Divide by three as a multiply by the rounded-up reciprocal; split the
  // product in two halves of the numerator and add them a stage later.
  // Decide the three-neighbour case on the way in.
  // --------------------------------------------------------------------------
  always_comb begin
    ldv_in    = late_f1_r;
    ldv_in.c2 = late_f1_r.d2 > {1'b0, late_f1_r.p2};
  end

  always_ff @(posedge clk) begin
    pl_r   <= (NL_W+RCP_W)'(n3_f1_r[NL_W-1:0]) * (NL_W+RCP_W)'(RCP_THIRD);
    ph_r   <= (NH_W+RCP_W)'(n3_f1_r[NUM_W-1:NL_W]) * (NH_W+RCP_W)'(RCP_THIRD);
    ldv1_r <= ldv_in;
  end

  assign prod = PROD_W'(pl_r) + {ph_r, NL_W'(0)};

  always_ff @(posedge clk) begin
    q_r    <= (VAL_W+1)'(prod[PROD_W-1:RCP_SHIFT]);
    ldv2_r <= ldv1_r;
  end

  // --------------------------------------------------------------------------
  // Pick the estimate and keep it only when strictly smaller in magnitude and not an interface cell.
  // --------------------------------------------------------------------------
  assign ldv_last = ldv2_r;
  assign d_nxt    = ldv_last.c2 ? q_r : ldv_last.d2;

  always_ff @(posedge clk) begin
    d_fa_r     <= d_nxt;
    upd_fa_r   <= !ldv_last.iface && (d_nxt < {1'b0, ldv_last.magh});
    neg_fa_r   <= ldv_last.neg;
    iface_fa_r <= ldv_last.iface;
    home_fa_r  <= ldv_last.home;
  end

  // Apply the sign; an update is always below 2^31 in magnitude.
  assign neg_d = ~d_fa_r[VAL_W-1:0] + VAL_W'(1);

  always_ff @(posedge clk) begin
    out_was_updated_r <= upd_fa_r;
    if (upd_fa_r) begin
      out_new_value_r <= neg_fa_r ? neg_d : d_fa_r[VAL_W-1:0];
    end else begin
      out_new_value_r <= home_fa_r;
    end
  end

  // Valid bits travel with the data; reset empties the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      vf1_r       <= 1'b0;
      vdv1_r      <= 1'b0;
      vdv2_r      <= 1'b0;
      vfa_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SQ_STAGES; k++) begin
        vq_r[k] <= 1'b0;
      end
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      vf1_r       <= vq_r[SQ_STAGES-1];
      vdv1_r      <= vf1_r;
      vdv2_r      <= vdv1_r;
      vfa_r       <= vdv2_r;
      out_valid_r <= vfa_r;
      for (int k = 0; k < SQ_STAGES; k++) begin
        vq_r[k] <= vq_in[k];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_value   = out_new_value_r;
  assign out_was_updated = out_was_updated_r;

`ifndef SYNTHESIS
  a_sort_order: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && cnt3_r >= CNT_W'(2) |-> p0_3_r <= p1_3_r)
    else $error("sorted neighbours out of order");

  a_keep_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_was_updated_r |-> out_new_value_r == $past(home_fa_r))
    else $error("unchanged result differs from home value");

  a_iface_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_was_updated_r |-> !$past(iface_fa_r))
    else $error("interface cell was updated");

  a_update_differs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_was_updated_r |-> out_new_value_r != $past(home_fa_r))
    else $error("update did not reduce the magnitude");
`endif

endmodule
